/* rtl/lip_pkg.sv */
// ---------------------------------------------------------------------------
// lip_pkg: shared types and constants for the line intersection block
// Widths of the exact intermediate values and the beat carried down the
// divider chain.
// ---------------------------------------------------------------------------
package lip_pkg;

   localparam int CoordW = 32;                 // Q16.16 coordinate
   localparam int DiffW  = CoordW + 1;         // exact difference
   localparam int ProdW  = 2 * DiffW;          // exact product
   localparam int SumW   = ProdW + 1;          // difference of products
   localparam int DenW   = SumW - 1;           // magnitude of M
   localparam int FracW  = 16;                 // fraction bits
   localparam int RemW   = DenW + FracW;       // shifted numerator magnitude
   localparam int QuoW   = 32;                 // quotient bits resolved
   localparam int TryW   = DenW + QuoW + 1;    // trial subtract width
   localparam int MulW   = CoordW + DiffW;     // ratio times direction
   localparam int AccW   = MulW - FracW + 1;   // base plus scaled step

   localparam logic signed [CoordW-1:0] SatMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic signed [CoordW-1:0] SatMin = {1'b1, {(CoordW-1){1'b0}}};

   // beat carried through the divider chain
   typedef struct packed {
      logic                     found;
      logic                     neg_r;
      logic                     neg_s;
      logic                     ovf_r;
      logic                     ovf_s;
      logic signed [DiffW-1:0]  dpx;
      logic signed [DiffW-1:0]  dpy;
      logic signed [CoordW-1:0] p1x;
      logic signed [CoordW-1:0] p1y;
      logic [DenW-1:0]          den;
      logic [RemW-1:0]          rem_r;
      logic [RemW-1:0]          rem_s;
      logic [QuoW-1:0]          quo_r;
      logic [QuoW-1:0]          quo_s;
   } lip_div_type;

   // saturate a sign and magnitude quotient to a signed 32-bit value
   function automatic logic signed [CoordW-1:0] sat_quo(
      input logic neg, input logic ovf, input logic [QuoW-1:0] q);
      logic signed [CoordW-1:0] res;
      if (!neg) begin
         res = (ovf || q[QuoW-1]) ? SatMax : $signed(q);
      end else if (ovf || (q[QuoW-1] && (q[QuoW-2:0] != '0))) begin
         res = SatMin;
      end else begin
         res = $signed(-q);
      end
      return res;
   endfunction

   // saturate the wide accumulator to a signed 32-bit value
   function automatic logic signed [CoordW-1:0] sat_acc(
      input logic signed [AccW-1:0] a);
      logic signed [CoordW-1:0] res;
      if (a > AccW'(SatMax)) begin
         res = SatMax;
      end else if (a < AccW'(SatMin)) begin
         res = SatMin;
      end else begin
         res = a[CoordW-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/line_intersection_params.sv */
// ---------------------------------------------------------------------------
// line_intersection_params: crossing of two lines, signed Q16.16
// Top level: front end, a chain of 32 divider cells, and the back end.
// ---------------------------------------------------------------------------
// Takes one beat per cycle when the result side does not stall, and returns
// one result beat per input, in order. The pipeline is five front stages
// (differences, products, determinant, magnitudes, overflow check), one
// divider cell per quotient bit (32), and two back stages. The whole pipeline
// advances together; a stall on the result side holds it and is passed to
// the request side in the same cycle. Parallel or coincident lines return
// found low and all other fields zero.
module line_intersection_params (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [lip_pkg::CoordW-1:0] req_p1_x,
   input  logic signed [lip_pkg::CoordW-1:0] req_p1_y,
   input  logic signed [lip_pkg::CoordW-1:0] req_p2_x,
   input  logic signed [lip_pkg::CoordW-1:0] req_p2_y,
   input  logic signed [lip_pkg::CoordW-1:0] req_q1_x,
   input  logic signed [lip_pkg::CoordW-1:0] req_q1_y,
   input  logic signed [lip_pkg::CoordW-1:0] req_q2_x,
   input  logic signed [lip_pkg::CoordW-1:0] req_q2_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic signed [lip_pkg::CoordW-1:0] rsp_ratio_r,
   output logic signed [lip_pkg::CoordW-1:0] rsp_ratio_s,
   output logic signed [lip_pkg::CoordW-1:0] rsp_cross_x,
   output logic signed [lip_pkg::CoordW-1:0] rsp_cross_y
);
   import lip_pkg::*;

   logic        adv;
   logic        chain_valid [QuoW+1];
   lip_div_type chain_beat  [QuoW+1];

   // advance unless a finished beat is held at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   lip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .p1_x      (req_p1_x),
      .p1_y      (req_p1_y),
      .p2_x      (req_p2_x),
      .p2_y      (req_p2_y),
      .q1_x      (req_q1_x),
      .q1_y      (req_q1_y),
      .q2_x      (req_q2_x),
      .q2_y      (req_q2_y),
      .out_valid (chain_valid[0]),
      .out_beat  (chain_beat[0])
   );

   // one cell per quotient bit, most significant first
   for (genvar i = 0; i < QuoW; i++) begin : g_cell
      lip_div_cell #(
         .BitIdx (QuoW - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_beat   (chain_beat[i]),
         .out_valid (chain_valid[i+1]),
         .out_beat  (chain_beat[i+1])
      );
   end

   lip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (chain_valid[QuoW]),
      .in_beat   (chain_beat[QuoW]),
      .out_valid (rsp_valid),
      .found     (rsp_found),
      .ratio_r   (rsp_ratio_r),
      .ratio_s   (rsp_ratio_s),
      .cross_x   (rsp_cross_x),
      .cross_y   (rsp_cross_y)
   );

   // parallel lines carry zero in every field
   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_ratio_r == '0 && rsp_ratio_s == '0 &&
                                  rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("parallel result carries nonzero fields");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held output freezes the chain
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> chain_valid[QuoW] == $past(chain_valid[QuoW]))
      else $error("divider chain moved during stall");

endmodule

/* rtl/lip_front.sv */
// ---------------------------------------------------------------------------
// lip_front: differences, products, determinant and divider setup
// Five register stages that turn two lines into the first beat of the
// divider chain: sign, magnitude and overflow flag of both ratios.
// ---------------------------------------------------------------------------
module lip_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [lip_pkg::CoordW-1:0] p1_x,
   input  logic signed [lip_pkg::CoordW-1:0] p1_y,
   input  logic signed [lip_pkg::CoordW-1:0] p2_x,
   input  logic signed [lip_pkg::CoordW-1:0] p2_y,
   input  logic signed [lip_pkg::CoordW-1:0] q1_x,
   input  logic signed [lip_pkg::CoordW-1:0] q1_y,
   input  logic signed [lip_pkg::CoordW-1:0] q2_x,
   input  logic signed [lip_pkg::CoordW-1:0] q2_y,
   output logic                              out_valid,
   output lip_pkg::lip_div_type              out_beat
);
   import lip_pkg::*;

   logic [4:0] valid_ff;

   logic signed [DiffW-1:0]  dpx1_ff, dpy1_ff, dqx1_ff, dqy1_ff, wx1_ff, wy1_ff;
   logic signed [CoordW-1:0] p1x1_ff, p1y1_ff;

   logic signed [ProdW-1:0]  mpa_ff, mpb_ff, nra_ff, nrb_ff, nsa_ff, nsb_ff;
   logic signed [DiffW-1:0]  dpx2_ff, dpy2_ff;
   logic signed [CoordW-1:0] p1x2_ff, p1y2_ff;

   logic signed [SumW-1:0]   m3_ff, nr3_ff, ns3_ff;
   logic signed [DiffW-1:0]  dpx3_ff, dpy3_ff;
   logic signed [CoordW-1:0] p1x3_ff, p1y3_ff;

   logic                     found4_ff, negr4_ff, negs4_ff;
   logic [DenW-1:0]          den4_ff, magr4_ff, mags4_ff;
   logic signed [DiffW-1:0]  dpx4_ff, dpy4_ff;
   logic signed [CoordW-1:0] p1x4_ff, p1y4_ff;

   lip_div_type beat_ff, beat_in;
   logic [DenW-1:0] den_abs, nr_abs, ns_abs;

   // advance the valid bits with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // magnitudes of the determinant and numerators
   always_comb begin
      den_abs = m3_ff[SumW-1]  ? DenW'(-m3_ff)  : DenW'(m3_ff);
      nr_abs  = nr3_ff[SumW-1] ? DenW'(-nr3_ff) : DenW'(nr3_ff);
      ns_abs  = ns3_ff[SumW-1] ? DenW'(-ns3_ff) : DenW'(ns3_ff);
   end

   // shift numerators and flag quotients of 2^32 or more
   always_comb begin
      beat_in       = '0;
      beat_in.found = found4_ff;
      beat_in.neg_r = negr4_ff;
      beat_in.neg_s = negs4_ff;
      beat_in.dpx   = dpx4_ff;
      beat_in.dpy   = dpy4_ff;
      beat_in.p1x   = p1x4_ff;
      beat_in.p1y   = p1y4_ff;
      beat_in.den   = den4_ff;
      beat_in.rem_r = {magr4_ff, FracW'(0)};
      beat_in.rem_s = {mags4_ff, FracW'(0)};
      beat_in.ovf_r = TryW'(beat_in.rem_r) >= (TryW'(den4_ff) << QuoW);
      beat_in.ovf_s = TryW'(beat_in.rem_s) >= (TryW'(den4_ff) << QuoW);
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         dpx1_ff <= DiffW'(p2_x) - DiffW'(p1_x);
         dpy1_ff <= DiffW'(p2_y) - DiffW'(p1_y);
         dqx1_ff <= DiffW'(q2_x) - DiffW'(q1_x);
         dqy1_ff <= DiffW'(q2_y) - DiffW'(q1_y);
         wx1_ff  <= DiffW'(q1_x) - DiffW'(p1_x);
         wy1_ff  <= DiffW'(q1_y) - DiffW'(p1_y);
         p1x1_ff <= p1_x;
         p1y1_ff <= p1_y;

         mpa_ff  <= ProdW'(dpx1_ff) * ProdW'(dqy1_ff);
         mpb_ff  <= ProdW'(dpy1_ff) * ProdW'(dqx1_ff);
         nra_ff  <= ProdW'(dqy1_ff) * ProdW'(wx1_ff);
         nrb_ff  <= ProdW'(dqx1_ff) * ProdW'(wy1_ff);
         nsa_ff  <= ProdW'(dpy1_ff) * ProdW'(wx1_ff);
         nsb_ff  <= ProdW'(dpx1_ff) * ProdW'(wy1_ff);
         dpx2_ff <= dpx1_ff;
         dpy2_ff <= dpy1_ff;
         p1x2_ff <= p1x1_ff;
         p1y2_ff <= p1y1_ff;

         m3_ff   <= SumW'(mpa_ff) - SumW'(mpb_ff);
         nr3_ff  <= SumW'(nra_ff) - SumW'(nrb_ff);
         ns3_ff  <= SumW'(nsa_ff) - SumW'(nsb_ff);
         dpx3_ff <= dpx2_ff;
         dpy3_ff <= dpy2_ff;
         p1x3_ff <= p1x2_ff;
         p1y3_ff <= p1y2_ff;

         found4_ff <= (m3_ff != '0);
         negr4_ff  <= nr3_ff[SumW-1] ^ m3_ff[SumW-1];
         negs4_ff  <= ns3_ff[SumW-1] ^ m3_ff[SumW-1];
         den4_ff   <= den_abs;
         magr4_ff  <= nr_abs;
         mags4_ff  <= ns_abs;
         dpx4_ff   <= dpx3_ff;
         dpy4_ff   <= dpy3_ff;
         p1x4_ff   <= p1x3_ff;
         p1y4_ff   <= p1y3_ff;

         beat_ff   <= beat_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_beat  = beat_ff;

endmodule

/* rtl/lip_div_cell.sv */
// ---------------------------------------------------------------------------
// lip_div_cell: one restoring division step for both ratios
// Resolves quotient bit BitIdx of r and s and hands the beat to the next cell.
// ---------------------------------------------------------------------------
module lip_div_cell #(
   parameter int BitIdx = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  lip_pkg::lip_div_type in_beat,
   output logic                 out_valid,
   output lip_pkg::lip_div_type out_beat
);
   import lip_pkg::*;

   logic        valid_ff;
   lip_div_type beat_ff, beat_in;
   logic [TryW-1:0] step, diff_r, diff_s;

   // trial subtract of the shifted divisor from both remainders
   always_comb begin
      beat_in = in_beat;
      step    = TryW'(in_beat.den) << BitIdx;
      diff_r  = TryW'(in_beat.rem_r) - step;
      diff_s  = TryW'(in_beat.rem_s) - step;
      if (!diff_r[TryW-1]) begin
         beat_in.rem_r         = diff_r[RemW-1:0];
         beat_in.quo_r[BitIdx] = 1'b1;
      end
      if (!diff_s[TryW-1]) begin
         beat_in.rem_s         = diff_s[RemW-1:0];
         beat_in.quo_s[BitIdx] = 1'b1;
      end
   end

   // hold the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // advance the beat
   always_ff @(posedge clock) begin
      if (adv) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

/* rtl/lip_back.sv */
// ---------------------------------------------------------------------------
// lip_back: ratio saturation and crossing point
// Saturates r and s, scales the first line's direction by r and adds p1;
// the last stage is the result register.
// ---------------------------------------------------------------------------
module lip_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  lip_pkg::lip_div_type              in_beat,
   output logic                              out_valid,
   output logic                              found,
   output logic signed [lip_pkg::CoordW-1:0] ratio_r,
   output logic signed [lip_pkg::CoordW-1:0] ratio_s,
   output logic signed [lip_pkg::CoordW-1:0] cross_x,
   output logic signed [lip_pkg::CoordW-1:0] cross_y
);
   import lip_pkg::*;

   logic [1:0] valid_ff;
   logic signed [CoordW-1:0] r_sat, s_sat;

   logic                     found1_ff;
   logic signed [CoordW-1:0] r1_ff, s1_ff, p1x1_ff, p1y1_ff;
   logic signed [MulW-1:0]   mx1_ff, my1_ff;
   logic signed [AccW-1:0]   ax, ay;

   logic                     found_ff;
   logic signed [CoordW-1:0] r_ff, s_ff, x_ff, y_ff;

   // saturate both ratios; parallel lines give zero
   always_comb begin
      r_sat = in_beat.found ? sat_quo(in_beat.neg_r, in_beat.ovf_r, in_beat.quo_r) : '0;
      s_sat = in_beat.found ? sat_quo(in_beat.neg_s, in_beat.ovf_s, in_beat.quo_s) : '0;
   end

   // drop the fraction of the step (floor) and add the base point
   always_comb begin
      ax = AccW'(p1x1_ff) + AccW'($signed(mx1_ff[MulW-1:FracW]));
      ay = AccW'(p1y1_ff) + AccW'($signed(my1_ff[MulW-1:FracW]));
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   // scale the direction, then saturate the crossing point
   always_ff @(posedge clock) begin
      if (adv) begin
         found1_ff <= in_beat.found;
         r1_ff     <= r_sat;
         s1_ff     <= s_sat;
         p1x1_ff   <= in_beat.p1x;
         p1y1_ff   <= in_beat.p1y;
         mx1_ff    <= MulW'(r_sat) * MulW'(in_beat.dpx);
         my1_ff    <= MulW'(r_sat) * MulW'(in_beat.dpy);

         found_ff  <= found1_ff;
         r_ff      <= r1_ff;
         s_ff      <= s1_ff;
         x_ff      <= found1_ff ? sat_acc(ax) : '0;
         y_ff      <= found1_ff ? sat_acc(ay) : '0;
      end
   end

   assign out_valid = valid_ff[1];
   assign found     = found_ff;
   assign ratio_r   = r_ff;
   assign ratio_s   = s_ff;
   assign cross_x   = x_ff;
   assign cross_y   = y_ff;

endmodule

/* tb/sv/line_intersection_params_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_intersection_params_tb: self-checking bench for the line crossing block
// Drives directed and random line pairs with bursty valid and a random stall
// pattern on the result side. A scoreboard predicts each result with exact
// wide arithmetic and checks the returned beats in order.
// ---------------------------------------------------------------------------
module line_intersection_params_tb;
   import lip_pkg::*;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      logic      found;
      coord_type ratio_r;
      coord_type ratio_s;
      coord_type cross_x;
      coord_type cross_y;
   } crossing_type;

   // exact crossing prediction and the queue of pending results
   class crossing_board;
      crossing_type pending[$];
      int           errors;

      function new();
         errors = 0;
      endfunction

      // saturate a wide signed value to 32 bits
      function coord_type clamp(logic signed [159:0] v);
         if (v > 160'sd2147483647) return SatMax;
         if (v < -160'sd2147483648) return SatMin;
         return v[31:0];
      endfunction

      // Q16.16 quotient truncated toward zero, then saturated
      function coord_type param_q16(logic signed [159:0] num, logic signed [159:0] den);
         logic signed [159:0] n, d, q;
         logic neg;
         neg = (num < 0) != (den < 0);
         n = (num < 0) ? -num : num;
         d = (den < 0) ? -den : den;
         q = (n <<< 16) / d;
         return clamp(neg ? -q : q);
      endfunction

      function void note_request(coord_type p1x, coord_type p1y,
                                 coord_type p2x, coord_type p2y,
                                 coord_type q1x, coord_type q1y,
                                 coord_type q2x, coord_type q2y);
         logic signed [159:0] dpx, dpy, dqx, dqy, wx, wy, det, nr, ns, prod;
         crossing_type e;
         dpx = 160'(p2x) - 160'(p1x);
         dpy = 160'(p2y) - 160'(p1y);
         dqx = 160'(q2x) - 160'(q1x);
         dqy = 160'(q2y) - 160'(q1y);
         wx  = 160'(q1x) - 160'(p1x);
         wy  = 160'(q1y) - 160'(p1y);
         det = dpx * dqy - dpy * dqx;
         e = '0;
         if (det != 0) begin
            nr = dqy * wx - dqx * wy;
            ns = dpy * wx - dpx * wy;
            e.found   = 1'b1;
            e.ratio_r = param_q16(nr, det);
            e.ratio_s = param_q16(ns, det);
            prod = 160'(e.ratio_r) * dpx;
            e.cross_x = clamp(160'(p1x) + (prod >>> 16));
            prod = 160'(e.ratio_r) * dpy;
            e.cross_y = clamp(160'(p1y) + (prod >>> 16));
         end
         pending.push_back(e);
      endfunction

      function void check_result(crossing_type got);
         crossing_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.found !== e.found) begin
            $display("%0t: found exp %0d got %0d", $time, e.found, got.found);
            errors++;
         end
         if (got.ratio_r !== e.ratio_r) begin
            $display("%0t: ratio_r exp %h got %h", $time, e.ratio_r, got.ratio_r);
            errors++;
         end
         if (got.ratio_s !== e.ratio_s) begin
            $display("%0t: ratio_s exp %h got %h", $time, e.ratio_s, got.ratio_s);
            errors++;
         end
         if (got.cross_x !== e.cross_x) begin
            $display("%0t: cross_x exp %h got %h", $time, e.cross_x, got.cross_x);
            errors++;
         end
         if (got.cross_y !== e.cross_y) begin
            $display("%0t: cross_y exp %h got %h", $time, e.cross_y, got.cross_y);
            errors++;
         end
      endfunction
   endclass

   logic      clock, reset;
   logic      req_valid, req_stall, rsp_valid, rsp_stall, rsp_found;
   coord_type req_p1_x, req_p1_y, req_p2_x, req_p2_y;
   coord_type req_q1_x, req_q1_y, req_q2_x, req_q2_y;
   coord_type rsp_ratio_r, rsp_ratio_s, rsp_cross_x, rsp_cross_y;
   bit        stim_done;

   crossing_board board;

   line_intersection_params dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("line_intersection_params test failed");
      $finish;
   end

   // pick a coordinate: full range, small, extreme or near zero
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 5))
         0: return SatMax;
         1: return SatMin;
         2: return coord_type'($urandom_range(0, 64) - 32) <<< 16;
         3: return coord_type'($urandom_range(0, 2000) - 1000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // send one request beat, holding it while stalled
   task automatic send_lines(coord_type p1x, coord_type p1y, coord_type p2x, coord_type p2y,
                             coord_type q1x, coord_type q1y, coord_type q2x, coord_type q2y);
      req_valid <= 1'b1;
      req_p1_x <= p1x; req_p1_y <= p1y; req_p2_x <= p2x; req_p2_y <= p2y;
      req_q1_x <= q1x; req_q1_y <= q1y; req_q2_x <= q2x; req_q2_y <= q2y;
      do @(posedge clock); while (req_stall);
      board.note_request(p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random line pair: mostly crossing lines, some parallel, some degenerate
   task automatic send_random();
      coord_type a, b, c, d, e, f;
      int        k;
      a = pick_coord(); b = pick_coord(); c = pick_coord(); d = pick_coord();
      e = pick_coord(); f = pick_coord();
      case ($urandom_range(0, 9))
         0: begin
            // first line's direction an integer multiple of the second's, so the lines are parallel
            k = $urandom_range(1, 3);
            send_lines(a, b, a + coord_type'(k) * (c >>> 4), b + coord_type'(k) * (d >>> 4),
                       e, f, e + (c >>> 4), f + (d >>> 4));
         end
         1: send_lines(a, b, a, b, e, f, c, d);
         default: send_lines(a, b, c, d, e, f, pick_coord(), pick_coord());
      endcase
   endtask

   // stimulus
   initial begin
      coord_type one;
      int        left, burst;
      board = new();
      one = coord_type'(1) <<< 16;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_p1_x, req_p1_y, req_p2_x, req_p2_y} = '0;
      {req_q1_x, req_q1_y, req_q2_x, req_q2_y} = '0;
      stim_done = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // crossing at the middle of both diagonals
      send_lines(0, 0, 2 * one, 2 * one, 0, 2 * one, 2 * one, 0);
      // parallel, coincident and point lines
      send_lines(0, 0, one, 0, 0, one, one, one);
      send_lines(0, 0, one, one, 2 * one, 2 * one, 3 * one, 3 * one);
      send_lines(one, one, one, one, 0, 0, one, 0);
      // crossing far outside the segments, negative and saturated parameters
      send_lines(0, 0, one, 0, -5 * one, -one, -5 * one, one);
      send_lines(0, 0, 1, 0, one, -one, one, one);
      // extremes: saturated parameters and crossing point
      send_lines(SatMin, SatMin, SatMax, SatMax, SatMin, SatMax, SatMax, SatMin);
      send_lines(SatMax, SatMin, SatMin, SatMax, SatMin, SatMin, SatMax, SatMax);
      send_lines(SatMin, 0, SatMax, 1, 0, SatMin, 1, SatMax);
      send_lines(0, 0, 1, 0, SatMax, SatMin, SatMax, SatMax);
      send_lines(SatMax, SatMax, SatMin, SatMax - 1, SatMin, SatMin, SatMin + 1, SatMax);
      send_lines(-1, -1, 0, 0, SatMax, 0, SatMax, 1);
      send_lines(0, 0, 1, 1, 0, 1, 1, 0);
      send_lines('1, 0, 0, '1, 0, 0, '1, '1);

      // drain once before random traffic
      idle_gap(1);
      while (board.pending.size() != 0) @(negedge clock);

      left = 640;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && left > 0) begin
            send_random();
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side: stall pattern of its own, quiet stretches included
   initial begin
      int phase;
      rsp_stall = 1'b1;
      phase = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         phase++;
         if ((phase / 200) % 3 == 2) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result({rsp_found, rsp_ratio_r, rsp_ratio_s, rsp_cross_x,
                             rsp_cross_y});
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0) begin
         $display("line_intersection_params test passed");
      end else begin
         $display("line_intersection_params test failed");
      end
      $finish;
   end

endmodule
